@@ sv/at_ipd_pkg.sv @@
// Shared types and constants for the AT +IPD response parser.
`timescale 1ns / 1ps
package at_ipd_pkg;

    localparam int BYTE_W = 8;
    localparam int CNT_W  = 7;   // message byte count, holds up to the store depth
    localparam int LEN_W  = 10;  // decimal length accumulator
    localparam int DCNT_W = 2;   // length digits taken so far

    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;  // '+'
    localparam logic [BYTE_W-1:0] CH_I     = 8'h49;  // 'I'
    localparam logic [BYTE_W-1:0] CH_P     = 8'h50;  // 'P'
    localparam logic [BYTE_W-1:0] CH_D     = 8'h44;  // 'D'
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;  // ','
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;  // ':'
    localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;  // newline
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;  // '9'

    // Controller -> datapath
    typedef struct packed {
        logic ready;      // accepting a receive transaction
        logic store;      // write held byte at count, bump count
        logic clr_cnt;    // drop stored bytes
        logic emit;       // latch message length/source, clear count, start readout
        logic payload;    // source flag for emit
        logic len_clr;    // restart length collection
        logic len_digit;  // fold held digit into length
        logic len_stop;   // non-digit seen in length
        logic len_sat;    // clamp length to store depth
        logic load;       // capture read data into output register
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic is_plus;
        logic is_i;
        logic is_p;
        logic is_d;
        logic is_comma;
        logic is_colon;
        logic is_nl;
        logic is_digit;
        logic cnt_full;        // store holds BUF_DEPTH bytes
        logic line_long;       // stored line has two bytes or more
        logic data_store_ok;   // payload byte still fits the announced length
        logic data_done;       // payload complete after this byte
        logic data_long;       // completed payload has two bytes or more
        logic digit_room;      // fewer than MAX_DIGITS digits taken
        logic stopped;         // length digits ended
        logic out_done;        // output transaction completed this cycle
        logic out_last;        // that transaction carried the final byte
    } t_dp_status;

endpackage

@@ sv/at_ipd_if.sv @@
// Valid/ready channel interfaces for received bytes and message bytes.
`timescale 1ns / 1ps
interface at_ipd_rx_if
    import at_ipd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface at_ipd_msg_if
    import at_ipd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic [CNT_W-1:0]  msg_length;
    logic              from_payload;
    logic              is_last;

    modport source (output valid, output data_byte, output msg_length,
                    output from_payload, output is_last, input ready);
    modport sink   (input valid, input data_byte, input msg_length,
                    input from_payload, input is_last, output ready);
endinterface

@@ sv/at_ipd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module at_ipd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ sv/at_ipd_ctrl.sv @@
// Parser controller: header phase tracking and message readout sequencing.
`timescale 1ns / 1ps
module at_ipd_ctrl
    import at_ipd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_accept,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);
    typedef enum logic [2:0] {
        S_IN, S_PARSE, S_RD, S_LD, S_OUT
    } t_seq;

    typedef enum logic [2:0] {
        PH_IDLE, PH_PLUS, PH_I, PH_P, PH_D, PH_LEN, PH_DATA
    } t_phase;

    t_seq    r_seq, n_seq;
    t_phase  r_phase, n_phase;
    t_dp_cmd n_cmd;

    always_comb begin
        n_seq   = r_seq;
        n_phase = r_phase;
        n_cmd   = '0;
        unique case (r_seq)
            S_IN: begin
                n_cmd.ready = 1'b1;
                if (i_rx_accept) begin
                    n_seq = S_PARSE;
                end
            end
            S_PARSE: begin
                n_seq = S_IN;
                unique case (r_phase)
                    PH_IDLE: begin
                        if (i_status.is_plus) begin
                            n_phase = PH_PLUS;
                        end else if (!i_status.is_nl && !i_status.cnt_full) begin
                            n_cmd.store = 1'b1;
                        end else if (i_status.line_long) begin
                            n_cmd.emit = 1'b1;
                            n_seq      = S_RD;
                        end else begin
                            n_cmd.clr_cnt = 1'b1;
                        end
                    end
                    PH_PLUS: n_phase = i_status.is_i ? PH_I : PH_IDLE;
                    PH_I:    n_phase = i_status.is_p ? PH_P : PH_IDLE;
                    PH_P:    n_phase = i_status.is_d ? PH_D : PH_IDLE;
                    PH_D: begin
                        if (i_status.is_comma) begin
                            n_cmd.len_clr = 1'b1;
                            n_phase       = PH_LEN;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_LEN: begin
                        if (i_status.is_colon) begin
                            n_cmd.len_sat = 1'b1;
                            n_cmd.clr_cnt = 1'b1;
                            n_phase       = PH_DATA;
                        end else if (!i_status.stopped) begin
                            if (i_status.is_digit) begin
                                n_cmd.len_digit = i_status.digit_room;
                            end else begin
                                n_cmd.len_stop = 1'b1;
                            end
                        end
                    end
                    PH_DATA: begin
                        n_cmd.store = i_status.data_store_ok;
                        if (i_status.data_done) begin
                            n_phase = PH_IDLE;
                            if (i_status.data_long) begin
                                n_cmd.emit    = 1'b1;
                                n_cmd.payload = 1'b1;
                                n_seq         = S_RD;
                            end else begin
                                n_cmd.clr_cnt = 1'b1;
                            end
                        end
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
            S_RD: n_seq = S_LD;
            S_LD: begin
                n_cmd.load = 1'b1;
                n_seq      = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_done) begin
                    n_seq = i_status.out_last ? S_IN : S_RD;
                end
            end
            default: n_seq = S_IN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq   <= S_IN;
            r_phase <= PH_IDLE;
        end else begin
            r_seq   <= n_seq;
            r_phase <= n_phase;
        end
    end

    assign o_cmd = n_cmd;
endmodule

@@ sv/at_ipd_dp.sv @@
// Parser datapath: byte decode, counters, length accumulator, store, output register.
`timescale 1ns / 1ps
module at_ipd_dp
    import at_ipd_pkg::*;
#(
    parameter int BUF_DEPTH  = 64,
    parameter int MAX_DIGITS = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rx_accept,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_status,
    at_ipd_msg_if.source      o_msg
);
    localparam int AW = $clog2(BUF_DEPTH);

    logic [BYTE_W-1:0] r_byte;
    logic [CNT_W-1:0]  r_cnt;
    logic [LEN_W-1:0]  r_len;
    logic [DCNT_W-1:0] r_dcnt;
    logic              r_stopped;
    logic [AW-1:0]     r_k;
    logic [CNT_W-1:0]  r_msg_len;
    logic              r_msg_from;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_data;
    logic [CNT_W-1:0]  r_out_len;
    logic              r_out_from;
    logic              r_out_last;

    logic [BYTE_W-1:0] w_rdata;
    logic [CNT_W-1:0]  w_post;
    logic [CNT_W-1:0]  w_data_post;
    logic [LEN_W-1:0]  w_len_next;
    logic [BYTE_W-1:0] w_digit;
    logic              w_out_done;

    at_ipd_ram #(.WIDTH(BYTE_W), .DEPTH(BUF_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.store),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (r_byte),
        .i_raddr (r_k),
        .o_rdata (w_rdata)
    );

    assign w_digit     = r_byte - CH_ZERO;
    assign w_len_next  = {r_len[LEN_W-4:0], 3'b000} + {r_len[LEN_W-2:0], 1'b0}
                       + LEN_W'(w_digit[3:0]);
    assign w_post      = r_cnt + CNT_W'(i_cmd.store);
    assign w_data_post = r_cnt + CNT_W'(o_status.data_store_ok);
    assign w_out_done  = r_out_valid && o_msg.ready;

    always_comb begin
        o_status               = '0;
        o_status.is_plus       = (r_byte == CH_PLUS);
        o_status.is_i          = (r_byte == CH_I);
        o_status.is_p          = (r_byte == CH_P);
        o_status.is_d          = (r_byte == CH_D);
        o_status.is_comma      = (r_byte == CH_COMMA);
        o_status.is_colon      = (r_byte == CH_COLON);
        o_status.is_nl         = (r_byte == CH_NL);
        o_status.is_digit      = (r_byte >= CH_ZERO) && (r_byte <= CH_NINE);
        o_status.cnt_full      = (r_cnt >= CNT_W'(BUF_DEPTH));
        o_status.line_long     = (r_cnt >= CNT_W'(2));
        o_status.data_store_ok = (LEN_W'(r_cnt) < r_len) && (r_cnt < CNT_W'(BUF_DEPTH));
        o_status.data_done     = (LEN_W'(w_data_post) >= r_len);
        o_status.data_long     = (w_data_post >= CNT_W'(2));
        o_status.digit_room    = (r_dcnt < DCNT_W'(MAX_DIGITS));
        o_status.stopped       = r_stopped;
        o_status.out_done      = w_out_done;
        o_status.out_last      = r_out_last;
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_rx_accept) begin
            r_byte <= i_rx_byte;
        end
        if (i_cmd.emit) begin
            r_msg_len  <= w_post;
            r_msg_from <= i_cmd.payload;
        end
        if (i_cmd.load) begin
            r_out_data <= w_rdata;
            r_out_len  <= r_msg_len;
            r_out_from <= r_msg_from;
            r_out_last <= (CNT_W'(r_k) + CNT_W'(1) == r_msg_len);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_len       <= '0;
            r_dcnt      <= '0;
            r_stopped   <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit || i_cmd.clr_cnt) begin
                r_cnt <= '0;
            end else if (i_cmd.store) begin
                r_cnt <= w_post;
            end

            if (i_cmd.len_clr) begin
                r_len     <= '0;
                r_dcnt    <= '0;
                r_stopped <= 1'b0;
            end else if (i_cmd.len_sat) begin
                if (r_len > LEN_W'(BUF_DEPTH)) begin
                    r_len <= LEN_W'(BUF_DEPTH);
                end
            end else if (i_cmd.len_digit) begin
                r_len  <= w_len_next;
                r_dcnt <= r_dcnt + DCNT_W'(1);
            end else if (i_cmd.len_stop) begin
                r_stopped <= 1'b1;
            end

            if (i_cmd.emit) begin
                r_k <= '0;
            end else if (w_out_done && !r_out_last) begin
                r_k <= r_k + AW'(1);
            end

            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (w_out_done) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_msg.valid        = r_out_valid;
    assign o_msg.data_byte    = r_out_data;
    assign o_msg.msg_length   = r_out_len;
    assign o_msg.from_payload = r_out_from;
    assign o_msg.is_last      = r_out_last;
endmodule

@@ sv/at_ipd_frame_parser_top.sv @@
// Top level of the AT command response parser with +IPD payload framing.
//
// Usage:
//   i_rx  : receive channel, one serial byte per transaction (valid/ready).
//   o_msg : message channel, one stored byte per transaction with the message
//           length, its source (0 text line, 1 +IPD payload) and a last flag.
// A text line ends on newline, or on any byte but '+' arriving while the
// store holds BUF_DEPTH bytes (that byte is dropped). "+IPD,<n>:" starts a
// counted payload of n bytes; only the first MAX_DIGITS digits count, n clamps
// to BUF_DEPTH. Messages shorter than two bytes are dropped without output.
// Every byte is accepted, then parsed. A finishing byte then starts the
// readout of its message, which any output stall holds up; each byte is
// read from the store RAM, loaded to the output register, then handed off.
// The next byte is read only after the previous one is handed off.
// i_rx.ready is low while a message drains; a stalled receiver on o_msg holds
// the output register and the readout in place, nothing is lost.
// Reset (synchronous, active low) returns to line collection with an empty
// count; store contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps
module at_ipd_frame_parser_top
    import at_ipd_pkg::*;
#(
    parameter int BUF_DEPTH  = 64,
    parameter int MAX_DIGITS = 3
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    at_ipd_rx_if.sink    i_rx,
    at_ipd_msg_if.source o_msg
);
    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_rx_accept;

    // receive transaction completes when the controller is in its accept state
    assign i_rx.ready  = w_cmd.ready;
    assign w_rx_accept = i_rx.valid && w_cmd.ready;

    at_ipd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_accept (w_rx_accept),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    at_ipd_dp #(
        .BUF_DEPTH  (BUF_DEPTH),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_accept (w_rx_accept),
        .i_rx_byte   (i_rx.rx_byte),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_msg       (o_msg)
    );
endmodule

@@ verif/at_ipd_frame_checker.sv @@
// Checker for the AT +IPD parser: predicts message transactions and compares them.
`timescale 1ns / 1ps
module at_ipd_frame_checker
    import at_ipd_pkg::*;
#(
    parameter int BUF_DEPTH  = 64,
    parameter int MAX_DIGITS = 3
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    at_ipd_rx_if  i_rx,
    at_ipd_msg_if i_msg,
    output int    o_fail_count,
    output int    o_pending
);

    typedef enum logic [2:0] {
        SCAN_LINE,
        SAW_PLUS,
        SAW_I,
        SAW_P,
        SAW_D,
        READ_LEN,
        TAKE_PAYLOAD
    } t_parse_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [CNT_W-1:0]  msg_length;
        logic              from_payload;
        logic              is_last;
    } t_msg_beat;

    t_parse_phase      phase = SCAN_LINE;
    logic [BYTE_W-1:0] line_store [BUF_DEPTH];
    logic [CNT_W-1:0]  stored_cnt = '0;
    logic [LEN_W-1:0]  len_acc = '0;
    logic [DCNT_W-1:0] digits = '0;
    logic              stopped = 1'b0;
    t_msg_beat         expected_beats [$];
    int                fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Queue one beat per stored byte; runs under two bytes are dropped.
    function automatic void queue_message(input logic payload);
        t_msg_beat beat;
        int        n;
        n = int'(stored_cnt);
        if (n >= 2) begin
            for (int k = 0; k < n; k++) begin
                beat.data_byte    = line_store[k];
                beat.msg_length   = CNT_W'(n);
                beat.from_payload = payload;
                beat.is_last      = (k == n - 1);
                expected_beats.push_back(beat);
            end
        end
    endfunction

    function automatic void predict_byte(input logic [BYTE_W-1:0] b);
        case (phase)
            SCAN_LINE: begin
                if (b == CH_PLUS) begin
                    phase = SAW_PLUS;
                end else if (b != CH_NL && stored_cnt < BUF_DEPTH) begin
                    line_store[stored_cnt] = b;
                    stored_cnt++;
                end else begin
                    // newline, or any byte but '+' on a full store
                    queue_message(1'b0);
                    stored_cnt = '0;
                end
            end
            SAW_PLUS: phase = (b == CH_I) ? SAW_I : SCAN_LINE;
            SAW_I:    phase = (b == CH_P) ? SAW_P : SCAN_LINE;
            SAW_P:    phase = (b == CH_D) ? SAW_D : SCAN_LINE;
            SAW_D: begin
                if (b == CH_COMMA) begin
                    phase   = READ_LEN;
                    len_acc = '0;
                    digits  = '0;
                    stopped = 1'b0;
                end else begin
                    phase = SCAN_LINE;
                end
            end
            READ_LEN: begin
                if (b == CH_COLON) begin
                    if (len_acc > BUF_DEPTH) len_acc = LEN_W'(BUF_DEPTH);
                    stored_cnt = '0;
                    phase      = TAKE_PAYLOAD;
                end else if (!stopped) begin
                    if (b >= CH_ZERO && b <= CH_NINE) begin
                        if (digits < MAX_DIGITS) begin
                            len_acc = LEN_W'(int'(len_acc) * 10 + int'(b - CH_ZERO));
                            digits++;
                        end
                    end else begin
                        stopped = 1'b1;
                    end
                end
            end
            TAKE_PAYLOAD: begin
                if (stored_cnt < len_acc && stored_cnt < BUF_DEPTH) begin
                    line_store[stored_cnt] = b;
                    stored_cnt++;
                end
                // zero length: this byte is swallowed and nothing comes out
                if (stored_cnt >= len_acc) begin
                    queue_message(1'b1);
                    stored_cnt = '0;
                    phase      = SCAN_LINE;
                end
            end
            default: phase = SCAN_LINE;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_msg_beat got;
        t_msg_beat want;
        if (!i_rst_n) begin
            phase      = SCAN_LINE;
            stored_cnt = '0;
            len_acc    = '0;
            digits     = '0;
            stopped    = 1'b0;
        end else begin
            // rx first: a result can never leave in the cycle its byte enters
            if (i_rx.valid && i_rx.ready) predict_byte(i_rx.rx_byte);
            if (i_msg.valid && i_msg.ready) begin
                got = '{i_msg.data_byte, i_msg.msg_length, i_msg.from_payload,
                        i_msg.is_last};
                if (expected_beats.size() == 0) begin
                    if (fails < 10)
                        $display("%0t: unexpected byte %02h len %0d src %0d last %0d",
                                 $realtime, got.data_byte, got.msg_length,
                                 got.from_payload, got.is_last);
                    fails++;
                end else begin
                    want = expected_beats.pop_front();
                    if (got !== want) begin
                        if (fails < 10) begin
                            $display("%0t: mismatch exp byte %02h len %0d src %0d last %0d",
                                     $realtime, want.data_byte, want.msg_length,
                                     want.from_payload, want.is_last);
                            $display("%0t:          got byte %02h len %0d src %0d last %0d",
                                     $realtime, got.data_byte, got.msg_length,
                                     got.from_payload, got.is_last);
                        end
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_beats.size();
    end

endmodule

@@ verif/tb.sv @@
// Testbench top for the AT +IPD parser: stimulus, output stalls and the verdict.
`timescale 1ns / 1ps
module tb;
    import at_ipd_pkg::*;

    localparam int BUF_DEPTH  = 64;
    localparam int MAX_DIGITS = 3;

    // Sized above the readout of a full store, for the final settle.
    localparam int SETTLE_CYCLES = 250;
    localparam int DRAIN_LIMIT   = 20000;

    logic i_clk;
    logic i_rst_n;

    at_ipd_rx_if  rx_ch ();
    at_ipd_msg_if msg_ch ();

    int chk_fail_count;
    int chk_pending;

    // Idle odds in percent per cycle, per side.
    int snd_idle_pct = 26;
    int rcv_idle_pct = 82;

    int bytes_sent   = 0;

    at_ipd_frame_parser_top #(
        .BUF_DEPTH (BUF_DEPTH),
        .MAX_DIGITS(MAX_DIGITS)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_rx   (rx_ch),
        .o_msg  (msg_ch)
    );

    at_ipd_frame_checker #(
        .BUF_DEPTH (BUF_DEPTH),
        .MAX_DIGITS(MAX_DIGITS)
    ) i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx        (rx_ch),
        .i_msg       (msg_ch),
        .o_fail_count(chk_fail_count),
        .o_pending   (chk_pending)
    );

    // 12 ns clock, starts low so the first edge is a clean rise
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Receiver side: ready drops at random, odds set per test phase.
    always @(posedge i_clk) begin
        msg_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // One rx transaction. Valid is only lowered when a gap is taken, so it never
    // sees a drop and a raise in the same step.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if ($urandom_range(99) < snd_idle_pct) begin
            rx_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < snd_idle_pct);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge i_clk); while (!rx_ch.ready);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) send_byte(s[k]);
    endtask

    // Hold the sender until every predicted message transaction has arrived, or
    // until DRAIN_LIMIT. The clock is always awaited after valid goes low.
    task automatic drain_results();
        int cycles;
        cycles = 0;
        rx_ch.valid <= 1'b0;
        do begin
            @(posedge i_clk);
            cycles++;
        end while (chk_pending != 0 && cycles < DRAIN_LIMIT);
    endtask

    // Plain text line. Bytes avoid '+' and newline so the length is known.
    // With fill set: flush, then 64 bytes fill the store and one more ends it.
    task automatic send_text_line(input bit fill);
        logic [BYTE_W-1:0] b;
        int                n;
        if (fill) begin
            send_byte(CH_NL);
            n = BUF_DEPTH + 1;
        end else begin
            n = $urandom_range(0, 8);
        end
        repeat (n) begin
            do b = BYTE_W'($urandom_range(255)); while (b == CH_PLUS || b == CH_NL);
            send_byte(b);
        end
        if (!fill) send_byte(CH_NL);
    endtask

    // "+IPD,<len>:" and its payload. The length field comes in several shapes:
    // plain decimal, leading zeros with surplus digits, a digit followed by junk,
    // or no digits at all. eff tracks the length the parser will settle on.
    task automatic send_ipd_frame(input bit big);
        logic [BYTE_W-1:0] len_field [$];
        logic [BYTE_W-1:0] junk;
        int                variant;
        int                n;
        int                d;
        int                eff;
        variant = $urandom_range(99);
        d       = $urandom_range(9);
        if (big) n = $urandom_range(65, 999);
        else if ($urandom_range(19) == 0) n = $urandom_range(40, 120);
        else n = $urandom_range(0, 9);

        if (big || variant < 70) begin
            if (n >= 100) len_field.push_back(BYTE_W'(CH_ZERO + n / 100));
            if (n >= 10) len_field.push_back(BYTE_W'(CH_ZERO + (n / 10) % 10));
            len_field.push_back(BYTE_W'(CH_ZERO + n % 10));
            eff = (n > BUF_DEPTH) ? BUF_DEPTH : n;
        end else if (variant < 85) begin
            // only the first three digits count: "00d" then ignored digits
            len_field.push_back(CH_ZERO);
            len_field.push_back(CH_ZERO);
            len_field.push_back(BYTE_W'(CH_ZERO + d));
            repeat ($urandom_range(1, 3))
                len_field.push_back(BYTE_W'(CH_ZERO + $urandom_range(9)));
            eff = d;
        end else if (variant < 95) begin
            // a non-digit ends the number, digits after it are ignored
            len_field.push_back(BYTE_W'(CH_ZERO + d));
            do junk = BYTE_W'($urandom_range(255));
            while ((junk >= CH_ZERO && junk <= CH_NINE) || junk == CH_COLON);
            len_field.push_back(junk);
            repeat ($urandom_range(0, 2))
                len_field.push_back(BYTE_W'(CH_ZERO + $urandom_range(9)));
            eff = d;
        end else begin
            eff = 0;
        end

        send_text("+IPD,");
        foreach (len_field[k]) send_byte(len_field[k]);
        send_byte(CH_COLON);
        // zero length still swallows one byte after the colon
        repeat ((eff == 0) ? 1 : eff) send_byte(BYTE_W'($urandom_range(255)));
    endtask

    task automatic send_random_frame();
        logic [BYTE_W-1:0] hdr [5];
        logic [BYTE_W-1:0] bad;
        int                r;
        int                k;
        hdr = '{CH_PLUS, CH_I, CH_P, CH_D, CH_COMMA};
        r   = $urandom_range(99);
        if (r < 50) begin
            send_ipd_frame(1'b0);
        end else if (r < 75) begin
            send_text_line(1'b0);
        end else if (r < 87) begin
            // header cut short by a wrong byte; the line so far survives
            k = $urandom_range(1, 4);
            for (int j = 0; j < k; j++) send_byte(hdr[j]);
            do bad = BYTE_W'($urandom_range(255)); while (bad == hdr[k]);
            send_byte(bad);
        end else if (r < 97) begin
            repeat ($urandom_range(1, 6)) send_byte(BYTE_W'($urandom_range(255)));
        end else begin
            send_text_line(1'b1);
        end
    endtask

    initial begin
        int rand_start;
        i_rst_n       = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        msg_ch.ready  = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed transactions.
        // Broken header inside a line ("+IX" vanishes), then 0xFF: line "A",FF.
        send_text("A+IX");
        send_byte(8'hFF);
        send_byte(CH_NL);
        // One-byte line is dropped.
        send_byte(8'h00);
        send_byte(CH_NL);
        // Payload of one byte: stored, then dropped as too short.
        send_text("+IPD,1:");
        send_byte(CH_NL);
        // No digits means length zero: next byte swallowed, nothing out.
        send_text("+IPD,:");
        send_byte("x");

        // Random part, phase 1: slow receiver, store filled to the brim at least once.
        rand_start = bytes_sent;
        send_text_line(1'b1);
        while (bytes_sent - rand_start < 70) send_random_frame();
        drain_results();

        // Phase 2: slow sender, fast receiver; one length above the store.
        snd_idle_pct = 82;
        rcv_idle_pct <= 26;
        send_ipd_frame(1'b1);
        while (bytes_sent - rand_start < 140) send_random_frame();
        drain_results();

        // Phase 3: back to back on both sides.
        snd_idle_pct = 0;
        rcv_idle_pct <= 0;
        while (bytes_sent - rand_start < 185) send_random_frame();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (chk_fail_count == 0 && chk_pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Hard stop, far beyond the slowest legal run.
    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ files.f @@
sv/at_ipd_pkg.sv
sv/at_ipd_if.sv
sv/at_ipd_ram.sv
sv/at_ipd_ctrl.sv
sv/at_ipd_dp.sv
sv/at_ipd_frame_parser_top.sv
verif/at_ipd_frame_checker.sv
verif/tb.sv
